@@ rtl/i2cfpl_pkg.sv @@
package i2cfpl_pkg;

  localparam int unsigned WORDS_PER_PAGE = 64;

  localparam logic [31:0] FLASH_BASE_RST = 32'h0800_0000;

  // event kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // commands
  localparam logic [7:0] CMD_STATUS     = 8'h00;
  localparam logic [7:0] CMD_FAST_WRITE = 8'h01;

  // page program phases
  localparam logic [2:0] PH_CLEAR = 3'd0;
  localparam logic [2:0] PH_BYTE0 = 3'd1;
  localparam logic [2:0] PH_BYTE1 = 3'd2;
  localparam logic [2:0] PH_BYTE2 = 3'd3;
  localparam logic [2:0] PH_BYTE3 = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  // status read positions
  localparam logic [7:0] POS_STATUS   = 8'd0;
  localparam logic [7:0] POS_PAGE     = 8'd1;
  localparam logic [7:0] POS_CHIP_ID  = 8'd2;
  localparam logic [7:0] POS_CAPACITY = 8'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_FLASH_BASE = 2'd0;
  localparam logic [1:0] CFG_CHIP_ID    = 2'd1;
  localparam logic [1:0] CFG_CAPACITY   = 2'd2;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_LOAD    = 2'd1,
    ACT_PROGRAM = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] flash_status;
  } in_beat_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] flash_address;
    logic [31:0] word_value;
    logic [7:0]  read_byte;
    logic        last;
  } out_beat_t;

  // results of one event handed to the output queue
  typedef struct packed {
    logic [1:0] num;
    out_beat_t  res0;
    out_beat_t  res1;
  } push_t;

endpackage

@@ rtl/i2cfpl_engine.sv @@
module i2cfpl_engine #(
  parameter int unsigned WordsPerPage = i2cfpl_pkg::WORDS_PER_PAGE
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  i2cfpl_pkg::in_beat_t in_beat_i,
  input  logic [31:0]          flash_base_i,
  input  logic [7:0]           chip_id_i,
  input  logic [7:0]           capacity_i,
  input  logic                 space_ok_i,
  output i2cfpl_pkg::push_t    push_o
);

  localparam int unsigned PageBytes = 4 * WordsPerPage;
  localparam logic [7:0]  LastPos   = 8'(WordsPerPage - 1);

  logic                 in_vld_q;
  i2cfpl_pkg::in_beat_t in_q;
  logic                 go;

  logic        expect_cmd_q, expect_cmd_d;
  logic        expect_page_q, expect_page_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  page_q, page_d;
  logic [7:0]  pos_q, pos_d;
  logic [2:0]  phase_q, phase_d;
  logic [23:0] acc_q, acc_d;
  logic [7:0]  sstat_q, sstat_d;
  logic [7:0]  spage_q, spage_d;
  logic [31:0] poff_q, poff_d;

  logic [31:0] page_addr;
  logic [31:0] word_addr;
  logic [7:0]  rb;
  i2cfpl_pkg::out_beat_t blank;

  assign go         = in_vld_q && space_ok_i;
  assign in_ready_o = !in_vld_q || go;

  // hold the beat until the queue has room for both results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_beat_i;
    end
  end

  assign page_addr = flash_base_i + poff_q;
  assign word_addr = page_addr + {22'd0, pos_q, 2'b00};

  always_comb begin
    rb = 8'd0;
    case (pos_q)
      i2cfpl_pkg::POS_STATUS:   rb = sstat_q;
      i2cfpl_pkg::POS_PAGE:     rb = spage_q;
      i2cfpl_pkg::POS_CHIP_ID:  rb = chip_id_i;
      i2cfpl_pkg::POS_CAPACITY: rb = capacity_i;
      default:                  rb = 8'd0;
    endcase
  end

  always_comb begin
    blank = '{action: i2cfpl_pkg::ACT_CLEAR, flash_address: 32'd0,
              word_value: 32'd0, read_byte: 8'd0, last: 1'b1};

    expect_cmd_d  = expect_cmd_q;
    expect_page_d = expect_page_q;
    cmd_d         = cmd_q;
    page_d        = page_q;
    pos_d         = pos_q;
    phase_d       = phase_q;
    acc_d         = acc_q;
    sstat_d       = sstat_q;
    spage_d       = spage_q;
    poff_d        = poff_q;
    push_o.num    = 2'd0;
    push_o.res0   = blank;
    push_o.res1   = blank;

    if (go) begin
      case (in_q.kind)
        i2cfpl_pkg::KIND_START: begin
          expect_cmd_d = 1'b1;
          pos_d        = page_q;
        end
        i2cfpl_pkg::KIND_WRITE: begin
          if (expect_cmd_q) begin
            cmd_d         = in_q.data;
            expect_cmd_d  = 1'b0;
            expect_page_d = 1'b1;
          end else if (expect_page_q) begin
            page_d        = in_q.data;
            poff_d        = 32'(in_q.data) * 32'(PageBytes);
            pos_d         = in_q.data;
            expect_page_d = 1'b0;
            if (cmd_q == i2cfpl_pkg::CMD_FAST_WRITE) begin
              phase_d = i2cfpl_pkg::PH_CLEAR;
              pos_d   = 8'd0;
            end
          end else if (cmd_q == i2cfpl_pkg::CMD_FAST_WRITE) begin
            unique case (phase_q)
              i2cfpl_pkg::PH_CLEAR: begin
                push_o.num = 2'd1;
                acc_d      = {16'd0, in_q.data};
                phase_d    = i2cfpl_pkg::PH_BYTE1;
              end
              i2cfpl_pkg::PH_BYTE0: begin
                acc_d   = {16'd0, in_q.data};
                phase_d = i2cfpl_pkg::PH_BYTE1;
              end
              i2cfpl_pkg::PH_BYTE1: begin
                acc_d   = acc_q | {8'd0, in_q.data, 8'd0};
                phase_d = i2cfpl_pkg::PH_BYTE2;
              end
              i2cfpl_pkg::PH_BYTE2: begin
                acc_d   = acc_q | {in_q.data, 16'd0};
                phase_d = i2cfpl_pkg::PH_BYTE3;
              end
              i2cfpl_pkg::PH_BYTE3: begin
                push_o.res0.action        = i2cfpl_pkg::ACT_LOAD;
                push_o.res0.flash_address = word_addr;
                push_o.res0.word_value    = {in_q.data, acc_q};
                if (pos_q == LastPos) begin
                  push_o.num                = 2'd2;
                  push_o.res0.last          = 1'b0;
                  push_o.res1.action        = i2cfpl_pkg::ACT_PROGRAM;
                  push_o.res1.flash_address = page_addr;
                  spage_d                   = page_q;
                  sstat_d                   = in_q.flash_status;
                  phase_d                   = i2cfpl_pkg::PH_DONE;
                end else begin
                  push_o.num = 2'd1;
                  pos_d      = pos_q + 8'd1;
                  phase_d    = i2cfpl_pkg::PH_BYTE0;
                end
              end
              default: begin
                // page already programmed: drop the byte
                pos_d = pos_q + 8'd1;
              end
            endcase
          end
        end
        i2cfpl_pkg::KIND_READ: begin
          push_o.num         = 2'd1;
          push_o.res0.action = i2cfpl_pkg::ACT_READ;
          if (cmd_q == i2cfpl_pkg::CMD_STATUS) begin
            push_o.res0.read_byte = rb;
            pos_d                 = pos_q + 8'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_cmd_q  <= 1'b1;
      expect_page_q <= 1'b0;
      cmd_q         <= 8'd0;
      page_q        <= 8'd0;
      pos_q         <= 8'd0;
      phase_q       <= i2cfpl_pkg::PH_CLEAR;
      acc_q         <= 24'd0;
      sstat_q       <= 8'd0;
      spage_q       <= 8'd0;
      poff_q        <= 32'd0;
    end else begin
      expect_cmd_q  <= expect_cmd_d;
      expect_page_q <= expect_page_d;
      cmd_q         <= cmd_d;
      page_q        <= page_d;
      pos_q         <= pos_d;
      phase_q       <= phase_d;
      acc_q         <= acc_d;
      sstat_q       <= sstat_d;
      spage_q       <= spage_d;
      poff_q        <= poff_d;
    end
  end

endmodule

@@ rtl/i2cfpl_outq.sv @@
module i2cfpl_outq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2cfpl_pkg::push_t     push_i,
  output logic                  space_ok_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output i2cfpl_pkg::out_beat_t out_beat_o
);

  i2cfpl_pkg::out_beat_t mem_q [4];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] wr_nxt;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_beat_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for a full two-result event
  assign space_ok_o  = (cnt_q <= 3'd2);
  assign wr_nxt      = wr_q + 2'd1;

  assign wr_d  = wr_q + push_i.num;
  assign rd_d  = rd_q + {1'b0, pop};
  assign cnt_d = cnt_q + {1'b0, push_i.num} - {2'b00, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_nxt] <= push_i.res1;
    end
  end

endmodule

@@ rtl/i2c_flash_page_loader_core.sv @@
// Flow: a beat accepted into the input register is decoded from there once
// the output queue has room, and its results are queued and offered from there.
// Throughput: one event per cycle while the queue has room for two results;
// a page-finishing byte pushes two results into the four-entry output queue.
// Reset: rst_ni clears the parser state and the queue at once; flash_base
// returns to 0x08000000 and the id and capacity bytes to zero.
module i2c_flash_page_loader_core #(
  parameter int unsigned WORDS_PER_PAGE = i2cfpl_pkg::WORDS_PER_PAGE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  i2cfpl_pkg::in_beat_t  in_beat_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output i2cfpl_pkg::out_beat_t out_beat_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [31:0]           cfg_wdata_i
);

  logic [31:0]       flash_base_q;
  logic [7:0]        chip_id_q;
  logic [7:0]        capacity_q;
  logic              space_ok;
  i2cfpl_pkg::push_t push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_base_q <= i2cfpl_pkg::FLASH_BASE_RST;
      chip_id_q    <= 8'd0;
      capacity_q   <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        i2cfpl_pkg::CFG_FLASH_BASE: flash_base_q <= cfg_wdata_i;
        i2cfpl_pkg::CFG_CHIP_ID:    chip_id_q    <= cfg_wdata_i[7:0];
        i2cfpl_pkg::CFG_CAPACITY:   capacity_q   <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  i2cfpl_engine #(
    .WordsPerPage(WORDS_PER_PAGE)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_beat_i    (in_beat_i),
    .flash_base_i (flash_base_q),
    .chip_id_i    (chip_id_q),
    .capacity_i   (capacity_q),
    .space_ok_i   (space_ok),
    .push_o       (push)
  );

  i2cfpl_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule
